// ===== rtl/core/sbr_pkg.sv =====
// shared types and constants of the substring removal filter
package sbr_pkg;

    localparam int BYTE_W   = 8;
    localparam int LEN_W    = 4;
    localparam int CFG_W    = 64;
    localparam int CFG_IDX_W = 1;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_LENGTH = 1'b0,
        REG_PATTERN_BYTES  = 1'b1
    } cfg_reg_t;

    // control broadcast to every cell of the hold chain
    typedef struct packed {
        logic              shift;
        logic [BYTE_W-1:0] wr_byte;
    } cell_ctrl_t;

endpackage

// ===== rtl/core/sbr_cell.sv =====
// one hold cell: a held byte, its pattern compare and the prefix chain link
module sbr_cell
(
    input  logic                        clk,
    input  sbr_pkg::cell_ctrl_t         ctrl,
    input  logic                        load,
    input  logic [sbr_pkg::BYTE_W-1:0]  right_byte,
    input  logic [sbr_pkg::BYTE_W-1:0]  pat_byte,
    input  logic                        left_ok,
    output logic [sbr_pkg::BYTE_W-1:0]  held_byte,
    output logic                        prefix_ok
);
    import sbr_pkg::*;

    logic [BYTE_W-1:0] byte_reg;
    logic [BYTE_W-1:0] byte_next;

    // append takes the new word, a pop takes the right neighbour's byte
    always_comb
    begin
        byte_next = byte_reg;
        if (load)
        begin
            byte_next = ctrl.wr_byte;
        end
        else if (ctrl.shift)
        begin
            byte_next = right_byte;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

    // prefix matches up to and including this cell
    assign held_byte = byte_reg;
    assign prefix_ok = left_ok && (byte_reg == pat_byte);

endmodule

// ===== rtl/core/substring_removal_filter.sv =====
// top level: hold chain of cells plus the scan and flush sequencer
// an accepted word is scanned in ST_SCAN and answered from the output register
// one input word at a time, held off by in_stall until scan and flush end; a mismatch pops
//   one held byte per cycle while the output is free, a last word flushes the held bytes
// reset: rst_n clears the sequencer, the hold count, the output valid flag and the
//   pattern registers; held bytes are not cleared and are only read once written
module substring_removal_filter #(
    parameter int MAX_PATTERN = 8
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [sbr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sbr_pkg::CFG_W-1:0]      cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [sbr_pkg::BYTE_W-1:0]     in_byte,
    input  logic                           in_last,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [sbr_pkg::BYTE_W-1:0]     out_byte,
    output logic                           has_byte,
    output logic                           out_last
);
    import sbr_pkg::*;

    localparam int CNT_W = $clog2(MAX_PATTERN + 1);
    localparam int PAT_W = BYTE_W * MAX_PATTERN;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               last_reg, last_next;
    logic [LEN_W-1:0]   len_reg;
    logic [PAT_W-1:0]   pat_reg;
    logic               out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]  out_byte_reg, out_byte_next;
    logic               has_byte_reg, has_byte_next;
    logic               out_last_reg, out_last_next;

    logic [CNT_W-1:0]   len_eff;
    logic               accept;
    logic               out_free;
    logic               emit;
    logic               match_cnt;
    cell_ctrl_t         ctrl;

    logic [BYTE_W-1:0]      cell_byte [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] cell_ok;
    logic [MAX_PATTERN-1:0] cell_load;
    logic [MAX_PATTERN-1:0] cell_at_cnt;

    // pattern length clamped to the chain depth
    assign len_eff = (len_reg > LEN_W'(MAX_PATTERN)) ? CNT_W'(MAX_PATTERN)
                                                     : CNT_W'(len_reg);

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign out_free = !out_valid_reg || !out_stall;

    // hold chain
    genvar i;
    generate
        for (i = 0; i < MAX_PATTERN; i++)
        begin : g_cell
            logic [BYTE_W-1:0] right_b;
            logic              left_ok;

            if (i == MAX_PATTERN - 1)
            begin : g_end
                assign right_b = cell_byte[i];
            end
            else
            begin : g_mid
                assign right_b = cell_byte[i+1];
            end

            if (i == 0)
            begin : g_head
                assign left_ok = 1'b1;
            end
            else
            begin : g_body
                assign left_ok = cell_ok[i-1];
            end

            assign cell_load[i]   = accept && (count_reg == CNT_W'(i));
            assign cell_at_cnt[i] = (count_reg == CNT_W'(i + 1));

            sbr_cell u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .load       (cell_load[i]),
                .right_byte (right_b),
                .pat_byte   (pat_reg[i*BYTE_W +: BYTE_W]),
                .left_ok    (left_ok),
                .held_byte  (cell_byte[i]),
                .prefix_ok  (cell_ok[i])
            );
        end
    endgenerate

    // held bytes equal the pattern prefix of the same length
    assign match_cnt = |(cell_ok & cell_at_cnt);

    // sequencer next state
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        last_next      = last_reg;
        emit           = 1'b0;
        out_byte_next  = out_byte_reg;
        has_byte_next  = has_byte_reg;
        out_last_next  = out_last_reg;
        ctrl.shift     = 1'b0;
        ctrl.wr_byte   = in_byte;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    count_next = count_reg + CNT_W'(1);
                    last_next  = in_last;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (count_reg == '0)
                begin
                    state_next = last_reg ? ST_FLUSH : ST_IDLE;
                end
                else if ((len_eff != '0) && (count_reg == len_eff) && match_cnt)
                begin
                    count_next = '0;
                    state_next = last_reg ? ST_FLUSH : ST_IDLE;
                end
                else if ((count_reg < len_eff) && match_cnt)
                begin
                    state_next = last_reg ? ST_FLUSH : ST_IDLE;
                end
                else if (out_free)
                begin
                    emit          = 1'b1;
                    out_byte_next = cell_byte[0];
                    has_byte_next = 1'b1;
                    out_last_next = 1'b0;
                    ctrl.shift    = 1'b1;
                    count_next    = count_reg - CNT_W'(1);
                end
            end
            ST_FLUSH:
            begin
                if (out_free)
                begin
                    emit = 1'b1;
                    if (count_reg != '0)
                    begin
                        out_byte_next = cell_byte[0];
                        has_byte_next = 1'b1;
                        out_last_next = 1'b0;
                        ctrl.shift    = 1'b1;
                        count_next    = count_reg - CNT_W'(1);
                    end
                    else
                    begin
                        out_byte_next = '0;
                        has_byte_next = 1'b0;
                        out_last_next = 1'b1;
                        state_next    = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output word register
    assign out_valid_next = emit || (out_valid_reg && out_stall);

    // state, count, last flag and output valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_byte_reg <= out_byte_next;
            has_byte_reg <= has_byte_next;
            out_last_reg <= out_last_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
            pat_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_PATTERN_LENGTH: len_reg <= cfg_data[LEN_W-1:0];
                REG_PATTERN_BYTES:  pat_reg <= cfg_data[PAT_W-1:0];
                default:            len_reg <= len_reg;
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign has_byte  = has_byte_reg;
    assign out_last  = out_last_reg;

endmodule

// ===== rtl/core/sbr_checker.sv =====
// port checker for the substring removal filter and its bind
module sbr_checker
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  logic [sbr_pkg::BYTE_W-1:0]     out_byte,
    input  logic                           has_byte,
    input  logic                           out_last
);
    import sbr_pkg::*;

    // a stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_byte)
            && $stable(has_byte) && $stable(out_last))
        else $error("stalled output word changed");

    // end marker carries no byte
    a_marker: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_last |-> !has_byte && (out_byte == '0))
        else $error("end marker carries a byte");

    // a word without a byte is always the end marker
    a_bare: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !has_byte |-> out_last)
        else $error("bare word without end flag");

    // one input word at a time: stall rises after each accept
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second word accepted while scanning");

endmodule

bind substring_removal_filter sbr_checker u_sbr_checker (.*);

// ===== sim/tb_substring_removal_filter.sv =====
// self-checking testbench of the substring removal filter
`timescale 1ns / 100ps

module tb_substring_removal_filter;

    import sbr_pkg::*;

    localparam int MAX_PAT        = 8;
    localparam int SETTLE_CYCLES  = MAX_PAT + 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_WORDS    = 25;
    localparam int PHASES         = 10;

    // one output word of the filter
    typedef struct {
        logic [BYTE_W-1:0] data;
        logic              has;
        logic              last;
    } out_word_t;

    // predicts the filtered stream and checks the words that come out
    class removal_scoreboard;
        logic [LEN_W-1:0]  pat_len;
        logic [CFG_W-1:0]  pat_bytes;
        logic [BYTE_W-1:0] held [MAX_PAT];
        int unsigned       held_cnt;
        out_word_t         expected_q [$];
        int unsigned       errors;
        int unsigned       checked;

        function new();
            pat_len   = '0;
            pat_bytes = '0;
            held_cnt  = 0;
            errors    = 0;
            checked   = 0;
        endfunction

        function void set_reg(cfg_reg_t idx, logic [CFG_W-1:0] value);
            if (idx == REG_PATTERN_LENGTH)
                pat_len = value[LEN_W-1:0];
            else
                pat_bytes = value;
        endfunction

        // lengths above the buffer size act as a full-size pattern
        function int unsigned usable_len();
            return (pat_len > MAX_PAT) ? MAX_PAT : pat_len;
        endfunction

        function bit held_prefix(int unsigned n);
            for (int unsigned i = 0; i < n; i++)
            begin
                if (held[i] != pat_bytes[8*i +: 8])
                    return 1'b0;
            end
            return 1'b1;
        endfunction

        function void push(logic [BYTE_W-1:0] b, logic has, logic last);
            out_word_t w;
            w.data = b;
            w.has  = has;
            w.last = last;
            expected_q.push_back(w);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // append, then drop a full match or emit until the buffer is a proper prefix
        function void note_input(logic [BYTE_W-1:0] b, logic last);
            int unsigned n;
            n = usable_len();
            held[held_cnt] = b;
            held_cnt++;
            while (held_cnt != 0)
            begin
                if (n > 0 && held_cnt == n && held_prefix(n))
                begin
                    held_cnt = 0;
                    break;
                end
                if (held_cnt < n && held_prefix(held_cnt))
                    break;
                push(held[0], 1'b1, 1'b0);
                for (int unsigned i = 1; i < held_cnt; i++)
                    held[i-1] = held[i];
                held_cnt--;
            end
            // end of string: flush the buffer, then a bare end marker
            if (last)
            begin
                for (int unsigned i = 0; i < held_cnt; i++)
                    push(held[i], 1'b1, 1'b0);
                held_cnt = 0;
                push('0, 1'b0, 1'b1);
            end
        endfunction

        task report(string msg);
            $display("ERROR at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(logic [BYTE_W-1:0] b, logic has, logic last);
            out_word_t w;
            checked++;
            if (expected_q.size() == 0)
                report($sformatf("unexpected word byte=%02h has=%b last=%b", b, has, last));
            else
            begin
                w = expected_q.pop_front();
                if (b !== w.data || has !== w.has || last !== w.last)
                    report($sformatf("word %0d: got byte=%02h has=%b last=%b, want %02h %b %b",
                                     checked, b, has, last, w.data, w.has, w.last));
            end
        endtask
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    logic [BYTE_W-1:0]    in_byte;
    logic                 in_last;
    logic                 out_valid;
    logic                 out_stall;
    logic [BYTE_W-1:0]    out_byte;
    logic                 has_byte;
    logic                 out_last;

    removal_scoreboard sb = new();
    bit          calm     = 1'b0;
    bit          activity = 1'b0;
    int unsigned words_in = 0;
    int unsigned settings = 0;
    int unsigned idle_cycles;

    substring_removal_filter #(
        .MAX_PATTERN (MAX_PAT)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_byte   (in_byte),
        .in_last   (in_last),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .has_byte  (has_byte),
        .out_last  (out_last)
    );

    // clock
    always #10 clk = ~clk;

    // mostly no gap, some short, a few long
    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // pattern bytes from a small alphabet so that overlaps and near misses are common
    function automatic logic [CFG_W-1:0] pick_pattern();
        logic [CFG_W-1:0] p;
        for (int k = 0; k < MAX_PAT; k++)
        begin
            case ($urandom_range(0, 4))
                0:       p[8*k +: 8] = 8'h00;
                1:       p[8*k +: 8] = 8'hFF;
                2:       p[8*k +: 8] = 8'h61;
                3:       p[8*k +: 8] = 8'h62;
                default: p[8*k +: 8] = BYTE_W'($urandom_range(0, 255));
            endcase
        end
        return p;
    endfunction

    // write the length register and then the pattern bytes register
    task automatic set_pattern(input logic [LEN_W-1:0] len, input logic [CFG_W-1:0] bytes);
        cfg_we    <= 1'b1;
        cfg_index <= REG_PATTERN_LENGTH;
        cfg_data  <= {{(CFG_W-LEN_W){1'b0}}, len};
        @(posedge clk);
        sb.set_reg(REG_PATTERN_LENGTH, {{(CFG_W-LEN_W){1'b0}}, len});
        cfg_index <= REG_PATTERN_BYTES;
        cfg_data  <= bytes;
        @(posedge clk);
        sb.set_reg(REG_PATTERN_BYTES, bytes);
        cfg_we <= 1'b0;
        settings++;
    endtask

    // present one word, hold it until taken, then maybe leave a gap
    task automatic send_word(input logic [BYTE_W-1:0] b, input logic last);
        int unsigned gap;
        in_valid <= 1'b1;
        in_byte  <= b;
        in_last  <= last;
        @(negedge clk);
        while (in_stall)
            @(negedge clk);
        sb.note_input(b, last);
        activity = 1'b1;
        words_in++;
        @(posedge clk);
        gap = calm ? 0 : gap_len();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // stop sending until every predicted word is out and the chain is quiet
    task automatic drain_and_settle();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // random strings built from whole patterns, prefixes, near misses and noise
    task automatic random_phase(input int unsigned words);
        logic [BYTE_W-1:0] chunk [$];
        int unsigned       sent;
        int unsigned       left;
        int unsigned       plen;
        int unsigned       cut;
        int unsigned       r;
        sent = 0;
        left = $urandom_range(1, 24);
        plen = sb.usable_len();
        while (sent < words)
        begin
            chunk.delete();
            r = $urandom_range(0, 99);
            if (plen == 0 || r < 25)
                chunk.push_back(BYTE_W'($urandom_range(0, 255)));
            else if (r < 65)
            begin
                for (int unsigned k = 0; k < plen; k++)
                    chunk.push_back(sb.pat_bytes[8*k +: 8]);
            end
            else if (r < 85)
            begin
                cut = $urandom_range(1, plen);
                for (int unsigned k = 0; k < cut; k++)
                    chunk.push_back(sb.pat_bytes[8*k +: 8]);
            end
            else
            begin
                for (int unsigned k = 0; k < plen; k++)
                    chunk.push_back(sb.pat_bytes[8*k +: 8]);
                cut = $urandom_range(0, plen - 1);
                chunk[cut] = chunk[cut] ^ (8'h01 << $urandom_range(0, 7));
            end
            foreach (chunk[k])
            begin
                left--;
                send_word(chunk[k], left == 0);
                if (left == 0)
                    left = $urandom_range(1, 24);
                sent++;
            end
            if ($urandom_range(0, 39) == 0)
                drain_and_settle();
        end
    endtask

    // receiver stall
    initial
    begin
        int unsigned stall_run;
        out_stall = 1'b0;
        stall_run = 0;
        forever
        begin
            @(posedge clk);
            if (stall_run > 0)
                stall_run--;
            else
                stall_run = calm ? 0 : gap_len();
            out_stall <= (stall_run > 0);
        end
    end

    // output monitor: a word seen here is taken at the next rising edge
    always @(negedge clk)
    begin
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            sb.check_result(out_byte, has_byte, out_last);
            activity = 1'b1;
        end
    end

    // watchdog on cycles without any accepted input word or checked output word
    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if (activity)
                idle_cycles = 0;
            else
                idle_cycles++;
            activity = 1'b0;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no progress for %0d cycles", idle_cycles);
                $display("substring_removal_filter: mismatch");
                $finish;
            end
        end
    end

    // main sequence
    initial
    begin
        logic [LEN_W-1:0] plen;
        logic [CFG_W-1:0] pbytes;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = REG_PATTERN_LENGTH;
        cfg_data  = '0;
        in_valid  = 1'b0;
        in_byte   = '0;
        in_last   = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty pattern after reset passes bytes straight through
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b1);
        drain_and_settle();

        // zero bytes in the pattern compare like any other value
        set_pattern(4'd3, 64'h0000_0000_0000_FF00);
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(8'h00, 1'b0);
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(8'h00, 1'b1);
        drain_and_settle();

        // pattern change while bytes are held mid-string
        set_pattern(4'd4, 64'h0000_0000_6261_6161);
        send_word(8'h61, 1'b0);
        send_word(8'h61, 1'b0);
        drain_and_settle();
        set_pattern(4'd2, 64'h0000_0000_0000_6261);
        send_word(8'h62, 1'b0);
        send_word(8'h63, 1'b1);
        drain_and_settle();

        // oversized length acts as a full eight-byte pattern
        set_pattern(4'd15, 64'h5555_5555_5555_5555);
        repeat (8) send_word(8'h55, 1'b0);
        send_word(8'h55, 1'b1);
        drain_and_settle();

        // random phases over a spread of pattern settings
        for (int ph = 0; ph < PHASES; ph++)
        begin
            pbytes = pick_pattern();
            case (ph)
                0:       plen = 4'd0;
                1:       plen = 4'd1;
                2:
                begin
                    plen   = 4'd8;
                    pbytes = '0;
                end
                3:
                begin
                    plen   = 4'd15;
                    pbytes = '1;
                end
                4:       plen = LEN_W'($urandom_range(9, 15));
                default: plen = LEN_W'($urandom_range(1, 8));
            endcase
            calm = (ph == 6);
            set_pattern(plen, pbytes);
            random_phase(PHASE_WORDS);
            drain_and_settle();
        end
        calm = 1'b0;
        send_word(BYTE_W'($urandom_range(0, 255)), 1'b1);
        drain_and_settle();

        $display("run covered %0d input words and %0d output words over %0d pattern settings",
                 words_in, sb.checked, settings);
        $display("settings included empty, single-byte, full, oversized and mid-string changes");
        if (sb.errors == 0)
            $display("substring_removal_filter: match");
        else
            $display("substring_removal_filter: mismatch");
        $finish;
    end

endmodule
